// ===== design/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Holds the transfer payload structs, operation and status codes, and the
// sequencer state type. No dependencies.
package ffha_pkg;

  // Header and granule geometry of the arena.
  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned GRAIN_BYTES = 8;
  // Smallest remainder worth splitting off: one header plus one granule.
  localparam int unsigned MIN_SPLIT = HDR_BYTES + GRAIN_BYTES;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_STATS   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FAIL    = 2'd1,
    STAT_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_bytes;
    logic [15:0] handle_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_offset;
    logic        moved;
    logic [15:0] copy_bytes;
    logic [15:0] free_bytes;
    logic [15:0] used_bytes;
    logic [15:0] max_free;
    logic [12:0] block_count;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR,   // clearing pass over the header memory after reset
    S_IDLE,    // waiting for an input transfer
    S_AL_CHK,  // first-fit walk, one header per cycle
    S_SP_CHK,  // split the chosen block if the remainder is large enough
    S_SP_WRB,  // write back the chosen block as used
    S_LK_CHK,  // handle lookup result
    S_RG_CHK,  // grow into the next block
    S_FR_ST,   // start of a free
    S_FM_CHK,  // forward merge with free successors
    S_BW_CHK,  // walk to the predecessor and merge backward
    S_FR_WRB,  // write back the freed block
    S_ST_CHK,  // statistics walk
    S_DONE     // hand the result to the output register
  } state_t;

endpackage

// ===== design/ffha_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the allocator's block header store.
module ffha_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator: sequencer over the header memory.
// Depends on ffha_pkg and ffha_ram.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid / in_ready   | in_data  (operation, size, handle)
//   out     | output    | out_valid / out_ready | out_data (status, offset, stats)
//
// One operation at a time. Each header visited on the list costs one read of
// the header memory's read port. A successful allocate walks the list, splits
// and writes back the chosen block; a failed allocate and statistics only walk
// the list; free and reallocate add a lookup of the handle's header, a forward
// merge and a backward walk to the predecessor. After reset a clearing pass
// writes every header entry with in_ready low. The final state, S_DONE,
// stretches while an earlier result still waits with out_ready low; a result
// waiting in the output register does not block the next input transfer.
module first_fit_heap_allocator_unit #(
  parameter int ARENA_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffha_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ffha_pkg::out_item_t out_data
);

  import ffha_pkg::*;

  localparam int AW = $clog2(ARENA_BYTES);          // byte offset width
  localparam int GRANULES = ARENA_BYTES / 8;
  localparam int GW = $clog2(GRANULES);             // header index width
  localparam int HW = 2 * AW + 2;                   // header entry width
  localparam int SW = AW + 1;                       // sums and end offsets
  localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;  // size compares
  localparam int NW = GW + 1;                       // header count

  function automatic logic [HW-1:0] hdr_pack(input logic [AW-1:0] sz,
                                             input logic [AW-1:0] nx,
                                             input logic us,
                                             input logic vl);
    return {sz, nx, us, vl};
  endfunction

  // Registers.
  state_t         state_r, state_nxt;
  logic [GW-1:0]  clr_r, clr_nxt;
  logic [CW-1:0]  want_r, want_nxt;
  logic           lk_free_r, lk_free_nxt;
  logic           move_r, move_nxt;
  logic [AW-1:0]  copy_r, copy_nxt;
  logic [AW-1:0]  off_r, off_nxt;
  logic [AW-1:0]  b_size_r, b_size_nxt;
  logic [AW-1:0]  b_next_r, b_next_nxt;
  logic           b_valid_r, b_valid_nxt;
  logic [AW-1:0]  walk_r, walk_nxt;
  logic [AW-1:0]  t_off_r, t_off_nxt;
  logic [AW-1:0]  t_size_r, t_size_nxt;
  logic [AW-1:0]  t_next_r, t_next_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [15:0]    res_pay_r, res_pay_nxt;
  logic           res_moved_r, res_moved_nxt;
  logic [15:0]    res_copy_r, res_copy_nxt;
  logic [SW-1:0]  fr_r, fr_nxt;
  logic [SW-1:0]  us_r, us_nxt;
  logic [AW-1:0]  lg_r, lg_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  // Header memory ports.
  logic           mem_we, mem_re;
  logic [GW-1:0]  mem_waddr, mem_raddr;
  logic [HW-1:0]  mem_wdata, mem_rdata;

  ffha_ram #(
    .WIDTH (HW),
    .DEPTH (GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Fields of the header just read.
  logic [AW-1:0] rd_size, rd_next;
  logic          rd_used, rd_valid;
  assign rd_size  = mem_rdata[HW-1 -: AW];
  assign rd_next  = mem_rdata[AW+1 -: AW];
  assign rd_used  = mem_rdata[1];
  assign rd_valid = mem_rdata[0];

  // Input decode: rounded size, handle checks, header offset of the handle.
  logic [CW-1:0] want_in;
  logic          h_ok_in;
  logic [AW-1:0] off_in;
  logic          accept;
  assign want_in = (CW'(in_data.request_bytes) + CW'(GRAIN_BYTES - 1)) &
                   ~CW'(GRAIN_BYTES - 1);
  assign h_ok_in = (in_data.handle_offset >= 16'(HDR_BYTES)) &&
                   (32'(in_data.handle_offset) < 32'(ARENA_BYTES)) &&
                   (in_data.handle_offset[2:0] == 3'd0);
  assign off_in  = AW'(in_data.handle_offset - 16'(HDR_BYTES));
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Shared conditions on the header just read.
  logic          al_fit, split_ok, lk_ok, lk_shrink, rg_ok, fm_ok;
  logic          bw_hit, bw_ok, out_free;
  logic [CW-1:0] rg_comb;
  logic [AW-1:0] sp_rem, sp_noff;
  assign al_fit    = rd_valid && !rd_used && (CW'(rd_size) >= want_r);
  assign sp_rem    = t_size_r - AW'(want_r);
  assign sp_noff   = t_off_r + AW'(HDR_BYTES) + AW'(want_r);
  assign split_ok  = (sp_rem >= AW'(MIN_SPLIT));
  assign lk_ok     = rd_valid && rd_used;
  assign lk_shrink = (want_r <= CW'(rd_size));
  assign rg_comb   = CW'(b_size_r) + CW'(HDR_BYTES) + CW'(rd_size);
  assign rg_ok     = rd_valid && !rd_used && (rg_comb >= want_r);
  assign fm_ok     = rd_valid && !rd_used &&
                     ((SW'(off_r) + SW'(HDR_BYTES) + SW'(b_size_r)) == SW'(b_next_r));
  assign bw_hit    = (rd_next == off_r);
  assign bw_ok     = !rd_used && b_valid_r &&
                     ((SW'(walk_r) + SW'(HDR_BYTES) + SW'(rd_size)) == SW'(off_r));
  assign out_free  = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == GW'(GRANULES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_data.operation))
            OP_ALLOC: begin
              state_nxt = (in_data.request_bytes == 16'd0) ? S_DONE : S_AL_CHK;
            end
            OP_FREE: begin
              state_nxt = (in_data.handle_offset != 16'd0 && h_ok_in) ? S_LK_CHK : S_DONE;
            end
            OP_REALLOC: begin
              priority if (in_data.handle_offset == 16'd0) begin
                state_nxt = (in_data.request_bytes == 16'd0) ? S_DONE : S_AL_CHK;
              end else if (h_ok_in) begin
                state_nxt = S_LK_CHK;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_STATS: state_nxt = S_ST_CHK;
          endcase
        end
      end
      S_AL_CHK: begin
        priority if (!rd_valid)      state_nxt = S_DONE;
        else if (al_fit)             state_nxt = S_SP_CHK;
        else if (rd_next == '0)      state_nxt = S_DONE;
      end
      S_SP_CHK: state_nxt = S_SP_WRB;
      S_SP_WRB: state_nxt = move_r ? S_FR_ST : S_DONE;
      S_LK_CHK: begin
        priority if (!lk_ok)         state_nxt = S_DONE;
        else if (lk_free_r)          state_nxt = S_FR_ST;
        else if (lk_shrink)          state_nxt = S_SP_CHK;
        else if (rd_next != '0)      state_nxt = S_RG_CHK;
        else                         state_nxt = S_AL_CHK;
      end
      S_RG_CHK: state_nxt = rg_ok ? S_SP_CHK : S_AL_CHK;
      S_FR_ST: begin
        priority if (b_next_r != '0) state_nxt = S_FM_CHK;
        else if (off_r != '0)        state_nxt = S_BW_CHK;
        else                         state_nxt = S_FR_WRB;
      end
      S_FM_CHK: begin
        priority if (fm_ok && rd_next != '0) state_nxt = S_FM_CHK;
        else if (off_r != '0)                state_nxt = S_BW_CHK;
        else                                 state_nxt = S_FR_WRB;
      end
      S_BW_CHK: begin
        if (!rd_valid || bw_hit || rd_next == '0) state_nxt = S_FR_WRB;
      end
      S_FR_WRB: state_nxt = S_DONE;
      S_ST_CHK: begin
        if (!rd_valid || rd_next == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath, memory accesses and result.
  always_comb begin
    clr_nxt        = clr_r;
    want_nxt       = want_r;
    lk_free_nxt    = lk_free_r;
    move_nxt       = move_r;
    copy_nxt       = copy_r;
    off_nxt        = off_r;
    b_size_nxt     = b_size_r;
    b_next_nxt     = b_next_r;
    b_valid_nxt    = b_valid_r;
    walk_nxt       = walk_r;
    t_off_nxt      = t_off_r;
    t_size_nxt     = t_size_r;
    t_next_nxt     = t_next_r;
    res_status_nxt = res_status_r;
    res_pay_nxt    = res_pay_r;
    res_moved_nxt  = res_moved_r;
    res_copy_nxt   = res_copy_r;
    fr_nxt         = fr_r;
    us_nxt         = us_r;
    lg_nxt         = lg_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Every entry invalid except the single free block at offset zero.
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_r == '0) ?
                    hdr_pack(AW'(ARENA_BYTES - HDR_BYTES), '0, 1'b0, 1'b1) : '0;
        clr_nxt   = clr_r + GW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          want_nxt       = want_in;
          lk_free_nxt    = (op_t'(in_data.operation) == OP_FREE) ||
                           (in_data.request_bytes == 16'd0);
          move_nxt       = 1'b0;
          off_nxt        = off_in;
          walk_nxt       = '0;
          res_status_nxt = STAT_OK;
          res_pay_nxt    = '0;
          res_moved_nxt  = 1'b0;
          res_copy_nxt   = '0;
          fr_nxt         = '0;
          us_nxt         = '0;
          lg_nxt         = '0;
          cnt_nxt        = '0;
          unique case (op_t'(in_data.operation))
            OP_ALLOC: begin
              if (in_data.request_bytes == 16'd0) res_status_nxt = STAT_FAIL;
              mem_re = 1'b1;
            end
            OP_FREE: begin
              if (in_data.handle_offset != 16'd0) begin
                if (h_ok_in) begin
                  mem_re    = 1'b1;
                  mem_raddr = off_in[AW-1:3];
                end else begin
                  res_status_nxt = STAT_INVALID;
                end
              end
            end
            OP_REALLOC: begin
              priority if (in_data.handle_offset == 16'd0) begin
                if (in_data.request_bytes == 16'd0) res_status_nxt = STAT_FAIL;
                mem_re = 1'b1;
              end else if (h_ok_in) begin
                mem_re    = 1'b1;
                mem_raddr = off_in[AW-1:3];
              end else begin
                res_status_nxt = STAT_INVALID;
              end
            end
            OP_STATS: mem_re = 1'b1;
          endcase
        end
      end
      S_AL_CHK: begin
        // First fit: take the first free header that is large enough.
        priority if (!rd_valid || (!al_fit && rd_next == '0)) begin
          res_status_nxt = STAT_FAIL;
          res_pay_nxt    = '0;
        end else if (al_fit) begin
          t_off_nxt  = walk_r;
          t_size_nxt = rd_size;
          t_next_nxt = rd_next;
        end else begin
          walk_nxt  = rd_next;
          mem_re    = 1'b1;
          mem_raddr = rd_next[AW-1:3];
        end
      end
      S_SP_CHK: begin
        // Carve the remainder into a new free header behind the block.
        if (split_ok) begin
          mem_we     = 1'b1;
          mem_waddr  = sp_noff[AW-1:3];
          mem_wdata  = hdr_pack(sp_rem - AW'(HDR_BYTES), t_next_r, 1'b0, 1'b1);
          t_size_nxt = AW'(want_r);
          t_next_nxt = sp_noff;
        end
      end
      S_SP_WRB: begin
        mem_we      = 1'b1;
        mem_waddr   = t_off_r[AW-1:3];
        mem_wdata   = hdr_pack(t_size_r, t_next_r, 1'b1, 1'b1);
        res_pay_nxt = 16'(SW'(t_off_r) + SW'(HDR_BYTES));
        if (move_r) begin
          res_moved_nxt = 1'b1;
          res_copy_nxt  = 16'(copy_r);
        end
      end
      S_LK_CHK: begin
        priority if (!lk_ok) begin
          res_status_nxt = STAT_INVALID;
        end else begin
          b_size_nxt  = rd_size;
          b_next_nxt  = rd_next;
          b_valid_nxt = 1'b1;
          priority if (lk_free_r) begin
            // Plain free, or reallocate to size zero.
          end else if (lk_shrink) begin
            t_off_nxt  = off_r;
            t_size_nxt = rd_size;
            t_next_nxt = rd_next;
          end else if (rd_next != '0) begin
            mem_re    = 1'b1;
            mem_raddr = rd_next[AW-1:3];
          end else begin
            // Move: allocate elsewhere first, the old block stays intact.
            move_nxt  = 1'b1;
            copy_nxt  = (CW'(rd_size) < want_r) ? rd_size : AW'(want_r);
            walk_nxt  = '0;
            mem_re    = 1'b1;
          end
        end
      end
      S_RG_CHK: begin
        if (rg_ok) begin
          // Absorb the free next block, then split as for a shrink.
          mem_we     = 1'b1;
          mem_waddr  = b_next_r[AW-1:3];
          mem_wdata  = '0;
          t_off_nxt  = off_r;
          t_size_nxt = AW'(rg_comb);
          t_next_nxt = rd_next;
        end else begin
          move_nxt = 1'b1;
          copy_nxt = (CW'(b_size_r) < want_r) ? b_size_r : AW'(want_r);
          walk_nxt = '0;
          mem_re   = 1'b1;
        end
      end
      S_FR_ST: begin
        priority if (b_next_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = b_next_r[AW-1:3];
        end else if (off_r != '0) begin
          walk_nxt = '0;
          mem_re   = 1'b1;
        end else begin
          walk_nxt = '0;
        end
      end
      S_FM_CHK: begin
        // Merge forward while the successor is free and adjacent.
        if (fm_ok) begin
          mem_we     = 1'b1;
          mem_waddr  = b_next_r[AW-1:3];
          mem_wdata  = '0;
          b_size_nxt = b_size_r + AW'(HDR_BYTES) + rd_size;
          b_next_nxt = rd_next;
        end
        if (fm_ok && rd_next != '0) begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[AW-1:3];
        end else if (off_r != '0) begin
          walk_nxt = '0;
          mem_re   = 1'b1;
        end
      end
      S_BW_CHK: begin
        // Find the predecessor and fold the freed block into it.
        priority if (!rd_valid) begin
        end else if (bw_hit) begin
          if (bw_ok) begin
            mem_we      = 1'b1;
            mem_waddr   = walk_r[AW-1:3];
            mem_wdata   = hdr_pack(rd_size + AW'(HDR_BYTES) + b_size_r, b_next_r,
                                   1'b0, 1'b1);
            b_valid_nxt = 1'b0;
          end
        end else if (rd_next != '0) begin
          walk_nxt  = rd_next;
          mem_re    = 1'b1;
          mem_raddr = rd_next[AW-1:3];
        end
      end
      S_FR_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = off_r[AW-1:3];
        mem_wdata = hdr_pack(b_size_r, b_next_r, 1'b0, b_valid_r);
      end
      S_ST_CHK: begin
        if (rd_valid) begin
          cnt_nxt = cnt_r + NW'(1);
          if (rd_used) begin
            us_nxt = us_r + SW'(rd_size);
          end else begin
            fr_nxt = fr_r + SW'(rd_size);
            if (rd_size > lg_r) lg_nxt = rd_size;
          end
          if (rd_next != '0) begin
            walk_nxt  = rd_next;
            mem_re    = 1'b1;
            mem_raddr = rd_next[AW-1:3];
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = res_status_r;
          out_data_nxt.payload_offset = res_pay_r;
          out_data_nxt.moved          = res_moved_r;
          out_data_nxt.copy_bytes     = res_copy_r;
          out_data_nxt.free_bytes     = 16'(fr_r);
          out_data_nxt.used_bytes     = 16'(us_r);
          out_data_nxt.max_free       = 16'(lg_r);
          out_data_nxt.block_count    = 13'(cnt_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    want_r       <= want_nxt;
    lk_free_r    <= lk_free_nxt;
    move_r       <= move_nxt;
    copy_r       <= copy_nxt;
    off_r        <= off_nxt;
    b_size_r     <= b_size_nxt;
    b_next_r     <= b_next_nxt;
    b_valid_r    <= b_valid_nxt;
    walk_r       <= walk_nxt;
    t_off_r      <= t_off_nxt;
    t_size_r     <= t_size_nxt;
    t_next_r     <= t_next_nxt;
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    res_moved_r  <= res_moved_nxt;
    res_copy_r   <= res_copy_nxt;
    fr_r         <= fr_nxt;
    us_r         <= us_nxt;
    lg_r         <= lg_nxt;
    cnt_r        <= cnt_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A header is never read in the cycle that it is written.
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("header read and write hit the same entry");

  // A moved block always comes with a successful, non-null result.
  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.moved) |->
      (out_data_r.status == STAT_OK && out_data_r.payload_offset != 16'd0))
    else $error("moved result without a new offset");

  // A failed or invalid request never returns an offset.
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != STAT_OK) |->
      (out_data_r.payload_offset == 16'd0))
    else $error("failed request returned an offset");

  // Returned offsets are granule aligned.
  a_pay_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.payload_offset[2:0] == 3'd0))
    else $error("payload offset not aligned");

  // One operation at a time: an input transfer is followed by a busy cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule
